### hw/rtl/pcl_pkg.sv
// Package for the PIN checker with retry lockout.
// Holds the beat and configuration types, command, status and register codes.
// Depends on nothing; every other file takes names from here by scope.
package pcl_pkg;

	// Field widths fixed by the interface.
	localparam int PIN_W     = 32;
	localparam int TALLY_W   = 8;
	localparam int TICKS_W   = 32;
	localparam int CMD_W     = 2;
	localparam int STATUS_W  = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 32;
	localparam int PIN_BYTES = PIN_W / 8;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_VERIFY = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CHANGE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_SUCCESS  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FAILED   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_MASTER   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_DURESS   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_LOCKED   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_NOVERIFY = 3'd5;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_DURESS_CODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MASTER_CODE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_FAILURES  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_TICKS = 2'd3;

	// Configuration reset values.
	localparam logic [TALLY_W-1:0] MAX_FAILURES_RST  = 8'd3;
	localparam logic [TICKS_W-1:0] LOCKOUT_TICKS_RST = 32'd30000;

	// Input beat.
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [PIN_W-1:0] pin_value;
	} in_t;

	// Result beat.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [TALLY_W-1:0]  failure_count;
		logic                is_locked;
		logic [TICKS_W-1:0]  remaining_ticks;
	} out_t;

	// Configuration register set as seen by the checker.
	typedef struct packed {
		logic [PIN_W-1:0]   duress_code;
		logic [PIN_W-1:0]   master_code;
		logic [TALLY_W-1:0] max_failures;
		logic [TICKS_W-1:0] lockout_ticks;
	} cfg_t;

	// Number of PIN bytes that take part, clamped to between one and the word.
	function automatic int eff_digits(input int digits);
		int n;
		n = digits;
		if (n > PIN_BYTES) n = PIN_BYTES;
		if (n < 1) n = 1;
		return n;
	endfunction

	// Mask that keeps the active PIN bytes.
	function automatic logic [PIN_W-1:0] pin_mask(input int digits);
		logic [PIN_W-1:0] m;
		int n;
		n = eff_digits(digits);
		m = '0;
		for (int i = 0; i < PIN_BYTES; i++) begin
			if (i < n) m[8*i +: 8] = 8'hFF;
		end
		return m;
	endfunction

endpackage

### hw/rtl/pin_check_with_lockout.sv
// PIN checker with retry lockout: input stage, decision logic, result register.
// Depends on pcl_pkg, pcl_cfg and pcl_state.

// One beat is accepted per clock when the result side keeps up: an input
// register holds the beat, the decision against the duress, master and stored
// codes plus the count and countdown update settle combinationally, and the
// result register holds the answer while the next beat is taken. Exactly one
// result beat leaves for every input beat. Configuration writes take effect
// at the next edge and are meant to be made while no beat is in flight. The
// stored PIN, failure count and lockout clear on reset; only the low
// CODE_DIGITS bytes of a PIN (at most four) take part in comparisons.
module pin_check_with_lockout #(
	parameter int CODE_DIGITS = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  pcl_pkg::in_t                  in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output pcl_pkg::out_t                 out_data,
	input  logic                          cfg_wr_en,
	input  logic [pcl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pcl_pkg::CFG_W-1:0]     cfg_data
);

	pcl_pkg::cfg_t cfg;
	pcl_pkg::in_t  item_s1;
	logic          valid_s1;
	pcl_pkg::out_t result;
	pcl_pkg::out_t out_data_q;
	logic          out_valid_q;
	logic          adv;

	// Configuration registers.
	pcl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The stage beat advances when the result register is free or draining.
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	// Input stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) item_s1 <= in_data;
	end

	// Decision logic and checker state.
	pcl_state #(
		.CODE_DIGITS (CODE_DIGITS)
	) u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) out_data_q <= result;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

### hw/rtl/pcl_cfg.sv
// Configuration register file of the PIN checker.
// Depends on pcl_pkg for the register indexes, reset values and cfg_t.
module pcl_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [pcl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pcl_pkg::CFG_W-1:0]     cfg_data,
	output pcl_pkg::cfg_t                 cfg
);

	pcl_pkg::cfg_t cfg_q;

	// Registers load on a write; no read-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.duress_code   <= '0;
			cfg_q.master_code   <= '0;
			cfg_q.max_failures  <= pcl_pkg::MAX_FAILURES_RST;
			cfg_q.lockout_ticks <= pcl_pkg::LOCKOUT_TICKS_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				pcl_pkg::CFG_DURESS_CODE: begin
					cfg_q.duress_code <= cfg_data[pcl_pkg::PIN_W-1:0];
				end
				pcl_pkg::CFG_MASTER_CODE: begin
					cfg_q.master_code <= cfg_data[pcl_pkg::PIN_W-1:0];
				end
				pcl_pkg::CFG_MAX_FAILURES: begin
					cfg_q.max_failures <= cfg_data[pcl_pkg::TALLY_W-1:0];
				end
				pcl_pkg::CFG_LOCKOUT_TICKS: begin
					cfg_q.lockout_ticks <= cfg_data[pcl_pkg::TICKS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### hw/rtl/pcl_state.sv
// Checker state and per-beat decision logic of the PIN checker.
// Depends on pcl_pkg for the beat types, codes and the PIN mask function.
module pcl_state #(
	parameter int CODE_DIGITS = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          upd,
	input  pcl_pkg::in_t  item,
	input  pcl_pkg::cfg_t cfg,
	output pcl_pkg::out_t result
);

	localparam logic [pcl_pkg::PIN_W-1:0] PinMask = pcl_pkg::pin_mask(CODE_DIGITS);
	localparam int NumDigits = pcl_pkg::eff_digits(CODE_DIGITS);

	logic [pcl_pkg::PIN_W-1:0]   user_code_q;
	logic [pcl_pkg::TALLY_W-1:0] tally_q;
	logic                        lock_q;
	logic [pcl_pkg::TICKS_W-1:0] countdown_q;

	logic [pcl_pkg::PIN_W-1:0]   user_code_d;
	logic [pcl_pkg::TALLY_W-1:0] tally_d;
	logic                        lock_d;
	logic [pcl_pkg::TICKS_W-1:0] countdown_d;
	logic [pcl_pkg::STATUS_W-1:0] status_d;
	logic [pcl_pkg::PIN_W-1:0]   pin_m;
	logic [pcl_pkg::TALLY_W-1:0] tally_inc;
	logic                        full_len;

	// Masked PIN, saturating failure count and full-length check.
	always_comb begin
		pin_m     = item.pin_value & PinMask;
		tally_inc = (tally_q == '1) ? tally_q : tally_q + 8'd1;
		full_len  = 1'b1;
		for (int i = 0; i < NumDigits; i++) begin
			if (item.pin_value[8*i +: 8] == 8'd0) full_len = 1'b0;
		end
	end

	// Next state and status for the beat in the input stage.
	always_comb begin
		user_code_d = user_code_q;
		tally_d     = tally_q;
		lock_d      = lock_q;
		countdown_d = countdown_q;
		status_d    = pcl_pkg::ST_NOVERIFY;
		case (item.cmd)
			pcl_pkg::CMD_VERIFY: begin
				if (lock_q) begin
					status_d = pcl_pkg::ST_LOCKED;
				end else if (pin_m == (cfg.duress_code & PinMask)) begin
					status_d    = pcl_pkg::ST_DURESS;
					tally_d     = '0;
					countdown_d = '0;
				end else if (pin_m == (cfg.master_code & PinMask)) begin
					status_d    = pcl_pkg::ST_MASTER;
					tally_d     = '0;
					countdown_d = '0;
				end else if (pin_m == (user_code_q & PinMask)) begin
					status_d    = pcl_pkg::ST_SUCCESS;
					tally_d     = '0;
					countdown_d = '0;
				end else begin
					status_d = pcl_pkg::ST_FAILED;
					tally_d  = tally_inc;
					if (tally_inc >= cfg.max_failures) begin
						lock_d      = 1'b1;
						countdown_d = cfg.lockout_ticks;
					end
				end
			end
			pcl_pkg::CMD_CHANGE: begin
				if (full_len) user_code_d = pin_m;
			end
			pcl_pkg::CMD_TICK: begin
				if (lock_q) begin
					if (countdown_q <= 32'd1) begin
						tally_d     = '0;
						lock_d      = 1'b0;
						countdown_d = '0;
					end else begin
						countdown_d = countdown_q - 32'd1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Result of the beat, taken from the state after it.
	always_comb begin
		result.status          = status_d;
		result.failure_count   = tally_d;
		result.is_locked       = lock_d;
		result.remaining_ticks = lock_d ? countdown_d : '0;
	end

	// State commits when the beat moves to the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			user_code_q <= '0;
			tally_q     <= '0;
			lock_q      <= 1'b0;
			countdown_q <= '0;
		end else if (upd) begin
			user_code_q <= user_code_d;
			tally_q     <= tally_d;
			lock_q      <= lock_d;
			countdown_q <= countdown_d;
		end
	end

	// The countdown is only non-zero during a lockout.
	a_idle_countdown: assert property (@(posedge clk) disable iff (!arst_n)
		!lock_q |-> countdown_q == '0)
		else $error("countdown non-zero while unlocked");

	// A lockout always follows at least one recorded failure.
	a_lock_tally: assert property (@(posedge clk) disable iff (!arst_n)
		lock_q |-> tally_q != '0)
		else $error("locked with zero failure count");

	// Only a failed verify can start a lockout.
	a_lock_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(lock_q) |-> $past(upd && item.cmd == pcl_pkg::CMD_VERIFY))
		else $error("lockout started without a verify");

	// A verify while locked leaves the count and the lock alone.
	a_locked_verify: assert property (@(posedge clk) disable iff (!arst_n)
		upd && lock_q && item.cmd == pcl_pkg::CMD_VERIFY
		|=> $stable(tally_q) && $stable(lock_q) && $stable(countdown_q))
		else $error("verify while locked changed state");

endmodule
